// ----- rtl/core/decimal_integer_range_check_defines.svh -----
// Assertion helpers shared by the RTL. Both expect clk and arst_n in scope.
`ifndef DECIMAL_INTEGER_RANGE_CHECK_DEFINES_SVH
`define DECIMAL_INTEGER_RANGE_CHECK_DEFINES_SVH

// Same-cycle implication.
`define DIRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DIRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/dirc_pkg.sv -----
package dirc_pkg;

	localparam int unsigned CharW    = 8;
	localparam int unsigned VerdictW = 2;
	localparam int unsigned ValW     = 64;
	localparam int unsigned CfgIdxW  = 2;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_LOW_BOUND  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_HIGH_BOUND = 2'd1;

	localparam logic signed [ValW-1:0] LOW_BOUND_RESET  = -64'sd2147483648;
	localparam logic signed [ValW-1:0] HIGH_BOUND_RESET = 64'sd2147483647;

	// Verdict codes
	localparam logic [VerdictW-1:0] VERDICT_OK     = 2'd0;
	localparam logic [VerdictW-1:0] VERDICT_FORMAT = 2'd1;
	localparam logic [VerdictW-1:0] VERDICT_RANGE  = 2'd2;
	localparam logic [VerdictW-1:0] VERDICT_UNUSED = 2'd3;

	// Character codes
	localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
	localparam logic [CharW-1:0] CH_ONE   = 8'h31;
	localparam logic [CharW-1:0] CH_NINE  = 8'h39;
	localparam logic [CharW-1:0] CH_MINUS = 8'h2d;

	// Accumulator limits for the times-ten step (quotients truncate toward zero)
	localparam logic signed [ValW-1:0] ACC_DIV_MAX = 64'sd922337203685477580;
	localparam logic signed [ValW-1:0] ACC_DIV_MIN = -64'sd922337203685477580;
	localparam logic signed [ValW-1:0] ACC_MIN     = {1'b1, {(ValW-1){1'b0}}};

	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_MINUS  = 3'b010,
		PH_DIGITS = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		DEC_NONE    = 2'd0,
		DEC_FORMAT  = 2'd1,
		DEC_RANGE   = 2'd2,
		DEC_ZERO_OK = 2'd3
	} dec_t;

	typedef struct packed {
		phase_t                 phase;
		logic                   negative;
		logic signed [ValW-1:0] acc;
		dec_t                   dec;
	} tok_t;

	localparam tok_t TOK_CLEAR = '{
		phase:    PH_FIRST,
		negative: 1'b0,
		acc:      '0,
		dec:      DEC_NONE
	};

endpackage

// ----- rtl/core/dirc_char_if.sv -----
interface dirc_char_if import dirc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] char_code;
	logic             last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ----- rtl/core/dirc_verdict_if.sv -----
interface dirc_verdict_if import dirc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VerdictW-1:0] verdict;

	modport source (output valid, output verdict, input ready);
	modport sink (input valid, input verdict, output ready);
endinterface

// ----- rtl/core/dirc_cfg_if.sv -----
interface dirc_cfg_if import dirc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [ValW-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/decimal_integer_range_check.sv -----
// Decimal integer token checker. Characters arrive one per transfer on chars, last_char set
// on the final one; that transfer yields one verdict on verdicts (0 valid, 1 bad format,
// 2 out of range) and clears the token state. A character can be taken every cycle: it is
// held in an input register, from which the times-ten update, the bound compare and the
// token state update run as one combinational pass, whose verdict for a final character
// goes to an output register. Only a final character waits on a verdict not yet taken;
// others keep flowing. Bounds are written through cfg (index 0 low bound, 1 high bound);
// users must write them only while no token is in flight; the block does not enforce it.
`include "decimal_integer_range_check_defines.svh"

module decimal_integer_range_check import dirc_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	dirc_char_if.sink      chars,
	dirc_verdict_if.source verdicts,
	dirc_cfg_if.sink       cfg
);

	logic signed [ValW-1:0] low_q;
	logic signed [ValW-1:0] high_q;

	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             last_s1;

	tok_t                tok_q;
	tok_t                tok_nxt;
	logic [VerdictW-1:0] verdict_nxt;

	logic                out_valid_q;
	logic [VerdictW-1:0] verdict_q;

	logic out_free, s1_go, s1_free;

	assign out_free = !out_valid_q || verdicts.ready;
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign s1_free  = !valid_s1 || s1_go;

	assign chars.ready      = s1_free;
	assign cfg.ready        = 1'b1;
	assign verdicts.valid   = out_valid_q;
	assign verdicts.verdict = verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_BOUND_RESET;
			high_q <= HIGH_BOUND_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_LOW_BOUND)
				low_q <= cfg.data;
			else if (cfg.index == REG_HIGH_BOUND)
				high_q <= cfg.data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_free)
			valid_s1 <= chars.valid;
	end

	always_ff @(posedge clk) begin
		if (chars.valid && s1_free) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
	end

	dirc_step u_step (
		.cur        (tok_q),
		.char_code  (char_s1),
		.last_char  (last_s1),
		.low_bound  (low_q),
		.high_bound (high_q),
		.nxt        (tok_nxt),
		.verdict    (verdict_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tok_q <= TOK_CLEAR;
		else if (s1_go)
			tok_q <= tok_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= s1_go && last_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1)
			verdict_q <= verdict_nxt;
	end

	`DIRC_ASSERT_NOW(a_verdict_code, out_valid_q, verdict_q != VERDICT_UNUSED, "bad verdict code")
	`DIRC_ASSERT_NEXT(a_token_clear, s1_go && last_s1, tok_q == TOK_CLEAR, "token not cleared")
	`DIRC_ASSERT_NOW(a_last_stall, valid_s1 && !s1_go, last_s1 && out_valid_q, "bad stall")
	`DIRC_ASSERT_NEXT(a_in_hold, valid_s1 && !s1_go, valid_s1 && $stable(char_s1), "input lost")
	`DIRC_ASSERT_NEXT(a_out_hold, out_valid_q && !verdicts.ready, out_valid_q && $stable(verdict_q), "verdict dropped")

endmodule

// ----- rtl/core/dirc_step.sv -----
module dirc_step import dirc_pkg::*; (
	input  tok_t                   cur,
	input  logic [CharW-1:0]       char_code,
	input  logic                   last_char,
	input  logic signed [ValW-1:0] low_bound,
	input  logic signed [ValW-1:0] high_bound,
	output tok_t                   nxt,
	output logic [VerdictW-1:0]    verdict
);

	logic signed [8:0]    digit;
	logic signed [ValW+4:0] acc_x;
	logic signed [ValW+4:0] prod;
	logic                 too_big;
	logic                 fits;
	logic                 add_ok;
	logic                 nz_digit;
	logic                 zero_ok;
	logic                 hit;
	tok_t                 upd;

	// acc * 10 + (code - 48), exact in 69 bits
	assign digit   = $signed({1'b0, char_code}) - 9'sd48;
	assign acc_x   = (ValW+5)'(cur.acc);
	assign prod    = (acc_x <<< 3) + (acc_x <<< 1) + (ValW+5)'(digit);
	assign too_big = (cur.acc > ACC_DIV_MAX) || (cur.acc < ACC_DIV_MIN);
	assign fits    = (prod[ValW+4:ValW-1] == '0) || (prod[ValW+4:ValW-1] == '1);
	assign add_ok  = !too_big && fits;

	assign nz_digit = (char_code >= CH_ONE) && (char_code <= CH_NINE);
	assign zero_ok  = !high_bound[ValW-1] && (low_bound[ValW-1] || (low_bound == '0));

	// bound check on the updated value; sign is still clear in the first phase
	dirc_bound u_bound (
		.acc        (prod[ValW-1:0]),
		.negative   (cur.negative),
		.low_bound  (low_bound),
		.high_bound (high_bound),
		.hit        (hit)
	);

	always_comb begin
		upd = cur;
		if (cur.dec == DEC_NONE) begin
			unique case (cur.phase)
				PH_FIRST: begin
					if (char_code == CH_ZERO) begin
						if (last_char)
							upd.dec = zero_ok ? DEC_ZERO_OK : DEC_RANGE;
						else
							upd.dec = DEC_FORMAT;
					end else if (char_code == CH_MINUS) begin
						upd.negative = 1'b1;
						upd.phase    = PH_MINUS;
					end else if (nz_digit) begin
						// accumulator is still clear here
						upd.phase = PH_DIGITS;
						if (add_ok) begin
							upd.acc = prod[ValW-1:0];
							if (hit)
								upd.dec = DEC_RANGE;
						end else begin
							upd.dec = DEC_RANGE;
						end
					end else begin
						upd.dec = DEC_FORMAT;
					end
				end
				PH_MINUS: begin
					if (nz_digit) begin
						upd.phase = PH_DIGITS;
						if (add_ok) begin
							upd.acc = prod[ValW-1:0];
							if (hit)
								upd.dec = DEC_RANGE;
						end else begin
							upd.dec = DEC_RANGE;
						end
					end else begin
						upd.dec = DEC_FORMAT;
					end
				end
				PH_DIGITS: begin
					// later characters are not checked to be digits
					if (add_ok) begin
						upd.acc = prod[ValW-1:0];
						if (hit)
							upd.dec = DEC_RANGE;
					end else begin
						upd.dec = DEC_RANGE;
					end
				end
				default: upd = cur;
			endcase
		end

		priority if (upd.dec == DEC_ZERO_OK)
			verdict = VERDICT_OK;
		else if (upd.dec != DEC_NONE)
			verdict = upd.dec;
		else if (upd.phase == PH_MINUS)
			verdict = VERDICT_FORMAT;
		else
			verdict = VERDICT_OK;

		nxt = last_char ? TOK_CLEAR : upd;
	end

endmodule

// ----- rtl/core/dirc_bound.sv -----
module dirc_bound import dirc_pkg::*; (
	input  logic signed [ValW-1:0] acc,
	input  logic                   negative,
	input  logic signed [ValW-1:0] low_bound,
	input  logic signed [ValW-1:0] high_bound,
	output logic                   hit
);

	logic signed [ValW:0] acc_w;
	logic signed [ValW:0] low_neg;
	logic                 neg_hit;
	logic                 pos_hit;

	// -acc < low  <=>  acc > -low, taken in 65 bits; -low depends on the register only
	assign acc_w   = (ValW+1)'(acc);
	assign low_neg = -((ValW+1)'(low_bound));
	assign neg_hit = (acc == ACC_MIN) || (acc_w > low_neg);
	assign pos_hit = acc > high_bound;
	assign hit     = negative ? neg_hit : pos_hit;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import dirc_pkg::*;

	localparam longint LMAX       = 64'sh7fff_ffff_ffff_ffff;
	localparam longint LMIN       = 64'sh8000_0000_0000_0000;
	localparam longint ACC_Q_MAX  = 64'sd922337203685477580;
	localparam int     QUIET_LIMIT = 4000;
	localparam int     PHASE_CHARS = 100;

	typedef struct packed {
		logic [CharW-1:0] code;
		logic             last;
	} char_item_t;

	logic clk;
	logic arst_n;

	dirc_char_if    chars_if ();
	dirc_verdict_if verdict_if ();
	dirc_cfg_if     cfg_if ();

	decimal_integer_range_check dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars_if),
		.verdicts (verdict_if),
		.cfg      (cfg_if)
	);

	char_item_t          char_backlog[$];
	logic [VerdictW-1:0] verdicts_due[$];
	logic [CharW-1:0]    tok_buf[$];
	char_item_t          drv_item;
	logic [VerdictW-1:0] due_verdict;

	// token scanner state and bound copies
	phase_t tok_phase;
	logic   tok_neg;
	longint tok_acc;
	dec_t   tok_dec;
	longint lo_bnd;
	longint hi_bnd;

	bit steady;
	int errors = 0;
	int quiet = 0;
	int ph;
	longint lo_new;
	longint hi_new;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic clear_token();
		tok_phase = PH_FIRST;
		tok_neg   = 1'b0;
		tok_acc   = 0;
		tok_dec   = DEC_NONE;
	endtask

	// times-ten step; fixes the verdict at out of range on overflow or a passed bound
	task automatic add_digit(input logic [CharW-1:0] c);
		longint d;
		longint t;
		d = c;
		d = d - 48;
		if (tok_acc > ACC_Q_MAX || tok_acc < -ACC_Q_MAX) begin
			tok_dec = DEC_RANGE;
			return;
		end
		t = tok_acc * 10;
		if ((d > 0 && t > LMAX - d) || (d < 0 && t < LMIN - d)) begin
			tok_dec = DEC_RANGE;
			return;
		end
		tok_acc = t + d;
		if (tok_neg) begin
			if (tok_acc == LMIN || -tok_acc < lo_bnd)
				tok_dec = DEC_RANGE;
		end else if (tok_acc > hi_bnd) begin
			tok_dec = DEC_RANGE;
		end
	endtask

	task automatic scan_char(input logic [CharW-1:0] c, input logic last);
		logic                nz;
		logic [VerdictW-1:0] v;
		nz = (c >= CH_ONE) && (c <= CH_NINE);
		if (tok_dec == DEC_NONE) begin
			case (tok_phase)
				PH_FIRST: begin
					if (c == CH_ZERO) begin
						if (last)
							tok_dec = (hi_bnd >= 0 && lo_bnd <= 0) ? DEC_ZERO_OK : DEC_RANGE;
						else
							tok_dec = DEC_FORMAT;
					end else if (c == CH_MINUS) begin
						tok_neg   = 1'b1;
						tok_phase = PH_MINUS;
					end else if (nz) begin
						tok_neg   = 1'b0;
						tok_acc   = 0;
						tok_phase = PH_DIGITS;
						add_digit(c);
					end else begin
						tok_dec = DEC_FORMAT;
					end
				end
				PH_MINUS: begin
					if (nz) begin
						tok_phase = PH_DIGITS;
						add_digit(c);
					end else begin
						tok_dec = DEC_FORMAT;
					end
				end
				default: add_digit(c);
			endcase
		end
		if (last) begin
			case (tok_dec)
				DEC_ZERO_OK: v = VERDICT_OK;
				DEC_FORMAT:  v = VERDICT_FORMAT;
				DEC_RANGE:   v = VERDICT_RANGE;
				default:     v = (tok_phase == PH_MINUS) ? VERDICT_FORMAT : VERDICT_OK;
			endcase
			verdicts_due.insert(verdicts_due.size(), v);
			clear_token();
		end
	endtask

	task automatic add_byte(input logic [CharW-1:0] c);
		tok_buf.insert(tok_buf.size(), c);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic commit_token();
		char_item_t it;
		for (int i = 0; i < tok_buf.size(); i++) begin
			it.code = tok_buf[i];
			it.last = (i == tok_buf.size() - 1);
			char_backlog.insert(char_backlog.size(), it);
		end
		tok_buf.delete();
	endtask

	task automatic gen_token();
		int               kind;
		int               n;
		int               sub;
		longint           v;
		longint           d;
		logic [CharW-1:0] rev[$];
		kind = $urandom_range(99);
		if (kind < 40) begin
			// well-formed number, mostly short
			if ($urandom_range(1))
				add_byte(CH_MINUS);
			n = ($urandom_range(3) == 0) ? $urandom_range(19, 1) : $urandom_range(6, 1);
			add_byte(8'(CH_ONE + $urandom_range(8)));
			for (int i = 1; i < n; i++)
				add_byte(8'(CH_ZERO + $urandom_range(9)));
		end else if (kind < 60) begin
			// just around a bound or zero
			case ($urandom_range(4))
				0: v = lo_bnd;
				1: v = hi_bnd;
				2: v = 0;
				3: v = -1;
				default: v = 1;
			endcase
			v = v + longint'($urandom_range(4)) - 2;
			add_text($sformatf("%0d", v));
		end else if (kind < 70) begin
			// steer the accumulator to a chosen value, using sub-'0' bytes when negative
			case ($urandom_range(3))
				0: v = LMIN;
				1: v = -ACC_Q_MAX;
				2: v = longint'({$urandom, $urandom});
				default: v = -longint'($urandom_range(5000));
			endcase
			if ($urandom_range(1))
				add_byte(CH_MINUS);
			while (!(v >= 1 && v <= 9)) begin
				if (v >= 10)
					d = v % 10;
				else
					d = v % 10 - 30;
				rev.push_front(8'(d + 48));
				v = (v - d) / 10;
			end
			add_byte(8'(v + 48));
			foreach (rev[i])
				add_byte(rev[i]);
		end else if (kind < 78) begin
			// 19 to 21 digits: 20 or more always overflow, 19 only when the value is large enough
			if ($urandom_range(1))
				add_byte(CH_MINUS);
			n = $urandom_range(21, 19);
			add_byte($urandom_range(1) ? CH_NINE : 8'(CH_ONE + $urandom_range(8)));
			for (int i = 1; i < n; i++)
				add_byte(8'(CH_ZERO + $urandom_range(9)));
		end else begin
			sub = $urandom_range(3);
			case (sub)
				0: begin
					n = $urandom_range(5, 1);
					for (int i = 0; i < n; i++)
						add_byte(8'($urandom_range(255)));
				end
				1: begin
					add_byte(CH_ZERO);
					n = $urandom_range(3, 1);
					for (int i = 0; i < n; i++)
						add_byte(8'(CH_ZERO + $urandom_range(9)));
				end
				2: begin
					add_byte(CH_MINUS);
					add_byte(8'($urandom_range(255)));
					n = $urandom_range(2);
					for (int i = 0; i < n; i++)
						add_byte(8'(CH_ZERO + $urandom_range(9)));
				end
				default: begin
					add_byte(8'(CH_ONE + $urandom_range(8)));
					add_byte(8'(CH_ZERO + $urandom_range(9)));
					add_byte(8'($urandom_range(255)));
					n = $urandom_range(3);
					for (int i = 0; i < n; i++)
						add_byte(8'(CH_ZERO + $urandom_range(9)));
				end
			endcase
		end
		commit_token();
	endtask

	task automatic write_bound(input logic [CfgIdxW-1:0] idx, input longint val);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		if (idx == REG_LOW_BOUND)
			lo_bnd = val;
		else
			hi_bnd = val;
	endtask

	// char driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_if.valid     <= 1'b0;
			chars_if.char_code <= '0;
			chars_if.last_char <= 1'b0;
			clear_token();
		end else begin
			if (chars_if.valid && chars_if.ready)
				scan_char(chars_if.char_code, chars_if.last_char);
			if (!chars_if.valid || chars_if.ready) begin
				if (char_backlog.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
					drv_item = char_backlog.pop_front();
					chars_if.valid     <= 1'b1;
					chars_if.char_code <= drv_item.code;
					chars_if.last_char <= drv_item.last;
				end else begin
					chars_if.valid <= 1'b0;
				end
			end
		end
	end

	// verdict monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_if.ready <= 1'b0;
		end else begin
			if (verdict_if.valid && verdict_if.ready) begin
				if (verdicts_due.size() == 0) begin
					report($sformatf("verdict %0d with no token pending", verdict_if.verdict));
				end else begin
					due_verdict = verdicts_due.pop_front();
					if (verdict_if.verdict !== due_verdict)
						report($sformatf("verdict %0d, expected %0d",
							verdict_if.verdict, due_verdict));
				end
			end
			verdict_if.ready <= steady || ($urandom_range(99) >= 33);
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((chars_if.valid && chars_if.ready) || (verdict_if.valid && verdict_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		steady = 1'b0;
		lo_bnd = LOW_BOUND_RESET;
		hi_bnd = HIGH_BOUND_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				case (ph)
					1: begin lo_new = LMIN; hi_new = LMAX; end
					2: begin lo_new = 1; hi_new = 100; end
					3: begin lo_new = -100; hi_new = -1; end
					4: begin lo_new = LMAX; hi_new = LMIN; end
					5: begin
						lo_new = longint'({$urandom, $urandom}) >>> $urandom_range(63, 1);
						hi_new = longint'({$urandom, $urandom}) >>> $urandom_range(63, 1);
					end
					default: begin lo_new = 0; hi_new = 0; end
				endcase
				if ($urandom_range(1)) begin
					write_bound(REG_LOW_BOUND, lo_new);
					write_bound(REG_HIGH_BOUND, hi_new);
				end else begin
					write_bound(REG_HIGH_BOUND, hi_new);
					write_bound(REG_LOW_BOUND, lo_new);
				end
			end
			@(negedge clk);
			steady = (ph == 5);
			if (ph == 0) begin
				add_text("0");  commit_token();
				add_text("00"); commit_token();
				add_text("07"); commit_token();
				add_text("-");  commit_token();
				add_text("-0"); commit_token();
				add_text("-7"); commit_token();
				add_text("8");  commit_token();
				add_text("a");  commit_token();
				add_text("-/"); commit_token();
				add_text("+3"); commit_token();
				add_byte(8'h00); commit_token();
				add_byte(8'hff); commit_token();
				// byte zero and a high byte as later characters
				add_text("1"); add_byte(8'h00); add_text("5"); commit_token();
				add_text("9"); add_byte(8'hff); commit_token();
			end
			while (char_backlog.size() < PHASE_CHARS)
				gen_token();
			while (char_backlog.size() != 0 || chars_if.valid || verdicts_due.size() != 0)
				@(negedge clk);
			repeat (8) @(negedge clk);
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/dirc_pkg.sv
rtl/core/dirc_char_if.sv
rtl/core/dirc_verdict_if.sv
rtl/core/dirc_cfg_if.sv
rtl/core/dirc_step.sv
rtl/core/dirc_bound.sv
rtl/core/decimal_integer_range_check.sv
tb/tb_top.sv
